// File: rtl/mpa_pkg.sv
// ----------------------------------------------------------------------------
// mpa_pkg
// Shared constants, register codes, command/status bundles and helpers for
// the 2-D max pooling block with argmax.
// ----------------------------------------------------------------------------
package mpa_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_KERNEL  = 8;
    localparam int SAMPLE_BITS = 16;

    localparam int COUNT_W  = $clog2(MAX_WIDTH);
    localparam int DIM_W    = COUNT_W + 1;
    localparam int KERNEL_W = 4;
    localparam int PAD_W    = 3;
    localparam int KSLOT_W  = $clog2(MAX_KERNEL);
    localparam int ARG_W    = 20;
    localparam int OPOS_W   = 21;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 3;

    localparam int ROW_SLOTS   = MAX_WIDTH + 1;
    localparam int STORE_DEPTH = MAX_KERNEL * ROW_SLOTS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ENTRY_W     = SAMPLE_BITS + ARG_W;
    localparam int DIV_STEPS   = DIM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_H = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_V = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_H    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_V    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_W  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_H  = 3'd7;

    typedef struct packed {
        logic accept;
        logic dim_start;
        logic dim_load;
        logic div_start;
        logic rng_load;
        logic rd;
        logic upd;
        logic step_j;
        logic step_i;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic ok;
        logic dirty;
        logic div_busy;
        logic rng_empty;
        logic j_end;
        logic i_end;
        logic emit;
        logic pend_valid;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [DIM_W-1:0] lo;
        logic [DIM_W-1:0] hi;
        logic             empty;
    } range_t;

    function automatic range_t axis_range(
        input logic [DIM_W-1:0]    q,
        input logic [KERNEL_W-1:0] rem,
        input logic [KERNEL_W-1:0] k,
        input logic [KERNEL_W-1:0] s,
        input logic [DIM_W-1:0]    n
    );
        logic [KERNEL_W-1:0] d;
        logic [KERNEL_W-1:0] mmax;
        range_t              rg;
        d    = k - KERNEL_W'(1) - rem;
        mmax = '0;
        for (int m = 1; m < MAX_KERNEL; m++) begin
            if ((8'(m) * {4'b0, s}) <= {4'b0, d}) begin
                mmax = KERNEL_W'(m);
            end
        end
        rg.lo    = (q > DIM_W'(mmax)) ? (q - DIM_W'(mmax)) : '0;
        rg.hi    = (q > (n - DIM_W'(1))) ? (n - DIM_W'(1)) : q;
        rg.empty = (rem >= k) || (rg.lo > rg.hi);
        return rg;
    endfunction

endpackage

// File: rtl/mpa_div.sv
// ----------------------------------------------------------------------------
// mpa_div
// Restoring divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module mpa_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mpa_pkg::DIM_W-1:0]     dividend,
    input  logic [mpa_pkg::KERNEL_W-1:0]  divisor,
    output logic                          busy,
    output logic [mpa_pkg::DIM_W-1:0]     quotient,
    output logic [mpa_pkg::KERNEL_W-1:0]  remainder
);
    import mpa_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIM_W-1:0]     quo_reg;
    logic [KERNEL_W-1:0]  rem_reg;
    logic [KERNEL_W-1:0]  div_reg;
    logic [KERNEL_W:0]    trial;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[DIM_W-1]};
    assign ge    = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            busy_reg <= cnt_reg != DIV_CNT_W'(1);
            cnt_reg  <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIM_W-2:0], ge};
            rem_reg <= ge ? KERNEL_W'(trial - {1'b0, div_reg}) : trial[KERNEL_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/mpa_datapath.sv
// ----------------------------------------------------------------------------
// mpa_datapath
// Configuration registers, position counters, window range dividers,
// partial maximum store, pending result and output register.
// ----------------------------------------------------------------------------
module mpa_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [mpa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mpa_pkg::CFG_W-1:0]            cfg_data,
    input  logic signed [mpa_pkg::SAMPLE_BITS-1:0] sample,
    input  mpa_pkg::cmd_t                        cmd,
    output mpa_pkg::status_t                     status,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic signed [mpa_pkg::SAMPLE_BITS-1:0] max_value,
    output logic [mpa_pkg::OPOS_W-1:0]           out_position,
    output logic [mpa_pkg::ARG_W-1:0]            arg_position,
    output logic                                 last
);
    import mpa_pkg::*;

    logic [KERNEL_W-1:0] kw_reg, kh_reg, sh_reg, sv_reg;
    logic [PAD_W-1:0]    ph_reg, pv_reg;
    logic [DIM_W-1:0]    w_reg, h_reg;
    logic                dirty_reg;

    logic [COUNT_W-1:0]  col_reg, row_reg;
    logic [COUNT_W-1:0]  c_reg, r_reg;
    logic signed [SAMPLE_BITS-1:0] v_reg;
    logic [ARG_W-1:0]    arg_reg;
    logic [DIM_W-1:0]    ow_reg, oh_reg;
    logic [DIM_W-1:0]    rh_reg, cl_reg, ch_reg, i_reg, j_reg;

    logic [ENTRY_W-1:0]  store_mem [STORE_DEPTH];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                open_reg, emit_reg;
    logic [OPOS_W-1:0]   opos_reg;

    logic                pend_valid_reg;
    logic signed [SAMPLE_BITS-1:0] pend_max_reg;
    logic [OPOS_W-1:0]   pend_opos_reg;
    logic [ARG_W-1:0]    pend_arg_reg;

    logic                out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_max_reg;
    logic [OPOS_W-1:0]   out_opos_reg;
    logic [ARG_W-1:0]    out_arg_reg;
    logic                out_last_reg;
    logic                out_valid_next;

    logic                ok;
    logic [DIM_W-1:0]    tc, tr;
    logic [DIM_W:0]      num_c, num_r;
    logic                div_start;
    logic [DIM_W-1:0]    dvd_c, dvd_r;
    logic                busy_c, busy_r;
    logic [DIM_W-1:0]    q_c, q_r;
    logic [KERNEL_W-1:0] rem_c, rem_r;
    range_t              rng_c, rng_r;

    logic [ADDR_W-1:0]   addr;
    logic [14:0]         js, is_v, ej, ei, ejr, eir, wl, hl;
    logic                open_col, top, last_col, bottom;
    logic [21:0]         oi;
    logic [20:0]         wr;

    logic signed [SAMPLE_BITS-1:0] rd_max;
    logic [ARG_W-1:0]    rd_arg;
    logic                newer;
    logic signed [SAMPLE_BITS-1:0] new_max;
    logic [ARG_W-1:0]    new_arg;
    logic                out_free;
    logic                out_load;
    logic [DIM_W-1:0]    c_inc, r_inc;

    // settings check
    assign ok = (kw_reg >= KERNEL_W'(1)) && (kw_reg <= KERNEL_W'(MAX_KERNEL))
             && (kh_reg >= KERNEL_W'(1)) && (kh_reg <= KERNEL_W'(MAX_KERNEL))
             && (sh_reg >= KERNEL_W'(1)) && (sv_reg >= KERNEL_W'(1))
             && ({1'b0, ph_reg} <= (kw_reg >> 1)) && ({1'b0, pv_reg} <= (kh_reg >> 1))
             && (w_reg >= DIM_W'(1)) && (w_reg <= DIM_W'(MAX_WIDTH))
             && (h_reg >= DIM_W'(1)) && (h_reg <= DIM_W'(MAX_HEIGHT))
             && (({1'b0, w_reg} + {{(DIM_W-PAD_W){1'b0}}, ph_reg, 1'b0})
                 >= (DIM_W+1)'(kw_reg))
             && (({1'b0, h_reg} + {{(DIM_W-PAD_W){1'b0}}, pv_reg, 1'b0})
                 >= (DIM_W+1)'(kh_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kw_reg    <= KERNEL_W'(2);
            kh_reg    <= KERNEL_W'(2);
            sh_reg    <= KERNEL_W'(2);
            sv_reg    <= KERNEL_W'(2);
            ph_reg    <= '0;
            pv_reg    <= '0;
            w_reg     <= DIM_W'(MAX_WIDTH);
            h_reg     <= DIM_W'(MAX_HEIGHT);
            dirty_reg <= 1'b1;
        end
        else
        begin
            if (cfg_write)
            begin
                dirty_reg <= 1'b1;
                case (cfg_index)
                    CFG_KERNEL_W: kw_reg <= cfg_data[KERNEL_W-1:0];
                    CFG_KERNEL_H: kh_reg <= cfg_data[KERNEL_W-1:0];
                    CFG_STRIDE_H: sh_reg <= cfg_data[KERNEL_W-1:0];
                    CFG_STRIDE_V: sv_reg <= cfg_data[KERNEL_W-1:0];
                    CFG_PAD_H:    ph_reg <= cfg_data[PAD_W-1:0];
                    CFG_PAD_V:    pv_reg <= cfg_data[PAD_W-1:0];
                    CFG_IMAGE_W:  w_reg  <= cfg_data[DIM_W-1:0];
                    CFG_IMAGE_H:  h_reg  <= cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            else if (cmd.dim_load)
            begin
                dirty_reg <= 1'b0;
            end
        end
    end

    // range dividers
    assign tc    = DIM_W'(c_reg) + DIM_W'(ph_reg);
    assign tr    = DIM_W'(r_reg) + DIM_W'(pv_reg);
    assign num_c = {1'b0, w_reg} + {{(DIM_W-PAD_W){1'b0}}, ph_reg, 1'b0}
                 - (DIM_W+1)'(kw_reg);
    assign num_r = {1'b0, h_reg} + {{(DIM_W-PAD_W){1'b0}}, pv_reg, 1'b0}
                 - (DIM_W+1)'(kh_reg);
    assign div_start = cmd.dim_start || cmd.div_start;
    assign dvd_c = cmd.dim_start ? num_c[DIM_W-1:0] : tc;
    assign dvd_r = cmd.dim_start ? num_r[DIM_W-1:0] : tr;

    mpa_div u_div_col (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dvd_c),
        .divisor   (sh_reg),
        .busy      (busy_c),
        .quotient  (q_c),
        .remainder (rem_c)
    );

    mpa_div u_div_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dvd_r),
        .divisor   (sv_reg),
        .busy      (busy_r),
        .quotient  (q_r),
        .remainder (rem_r)
    );

    assign rng_c = axis_range(q_c, rem_c, kw_reg, sh_reg, ow_reg);
    assign rng_r = axis_range(q_r, rem_r, kh_reg, sv_reg, oh_reg);

    // counters
    assign c_inc = DIM_W'(c_reg) + DIM_W'(1);
    assign r_inc = DIM_W'(r_reg) + DIM_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.fin)
        begin
            if (c_inc >= w_reg)
            begin
                col_reg <= '0;
                row_reg <= (r_inc >= h_reg) ? '0 : r_inc[COUNT_W-1:0];
            end
            else
            begin
                col_reg <= c_inc[COUNT_W-1:0];
            end
        end
    end

    // per-slot flags
    assign addr = ADDR_W'(i_reg[KSLOT_W-1:0]) * ADDR_W'(ROW_SLOTS) + ADDR_W'(j_reg);
    assign js   = {4'b0, j_reg} * {11'b0, sh_reg};
    assign is_v = {4'b0, i_reg} * {11'b0, sv_reg};
    assign ej   = js + 15'(kw_reg) - 15'd1;
    assign ei   = is_v + 15'(kh_reg) - 15'd1;
    assign ejr  = (ej > 15'(ph_reg)) ? (ej - 15'(ph_reg)) : '0;
    assign eir  = (ei > 15'(pv_reg)) ? (ei - 15'(pv_reg)) : '0;
    assign wl   = 15'(w_reg) - 15'd1;
    assign hl   = 15'(h_reg) - 15'd1;
    assign open_col = ((js > 15'(ph_reg)) ? js : 15'(ph_reg)) == 15'(tc);
    assign top      = ((is_v > 15'(pv_reg)) ? is_v : 15'(pv_reg)) == 15'(tr);
    assign last_col = ((ejr > wl) ? wl : ejr) == 15'(c_reg);
    assign bottom   = ((eir > hl) ? hl : eir) == 15'(r_reg);
    assign oi = {11'b0, ow_reg} * {11'b0, i_reg};
    assign wr = {10'b0, w_reg} * {11'b0, r_reg};

    assign rd_max  = rd_data_reg[ENTRY_W-1:ARG_W];
    assign rd_arg  = rd_data_reg[ARG_W-1:0];
    assign newer   = open_reg || (v_reg > rd_max);
    assign new_max = newer ? v_reg : rd_max;
    assign new_arg = newer ? arg_reg : rd_arg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            v_reg <= sample;
            c_reg <= ({1'b0, col_reg} >= w_reg) ? '0 : col_reg;
            r_reg <= ({1'b0, row_reg} >= h_reg) ? '0 : row_reg;
        end
        if (cmd.div_start)
        begin
            arg_reg <= wr[ARG_W-1:0] + ARG_W'(c_reg);
        end
        if (cmd.dim_load)
        begin
            ow_reg <= q_c + DIM_W'(1);
            oh_reg <= q_r + DIM_W'(1);
        end
        if (cmd.rng_load)
        begin
            rh_reg <= rng_r.hi;
            cl_reg <= rng_c.lo;
            ch_reg <= rng_c.hi;
            i_reg  <= rng_r.lo;
            j_reg  <= rng_c.lo;
        end
        else if (cmd.step_i)
        begin
            i_reg <= i_reg + DIM_W'(1);
            j_reg <= cl_reg;
        end
        else if (cmd.step_j)
        begin
            j_reg <= j_reg + DIM_W'(1);
        end
        if (cmd.rd)
        begin
            rd_data_reg <= store_mem[addr];
            addr_reg    <= addr;
            open_reg    <= top && open_col;
            opos_reg    <= OPOS_W'(j_reg) + oi[OPOS_W-1:0];
        end
        if (cmd.upd && newer)
        begin
            store_mem[addr_reg] <= {v_reg, arg_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg <= 1'b0;
        end
        else if (cmd.rd)
        begin
            emit_reg <= bottom && last_col;
        end
    end

    // pending result and output register
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = pend_valid_reg && ((cmd.upd && emit_reg) || cmd.fin);
    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.fin)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.upd && emit_reg)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd && emit_reg)
        begin
            pend_max_reg  <= new_max;
            pend_opos_reg <= opos_reg;
            pend_arg_reg  <= new_arg;
        end
        if (out_load)
        begin
            out_max_reg  <= pend_max_reg;
            out_opos_reg <= pend_opos_reg;
            out_arg_reg  <= pend_arg_reg;
            out_last_reg <= cmd.fin;
        end
    end

    assign status.ok         = ok;
    assign status.dirty      = dirty_reg;
    assign status.div_busy   = busy_c || busy_r;
    assign status.rng_empty  = rng_c.empty || rng_r.empty;
    assign status.j_end      = j_reg == ch_reg;
    assign status.i_end      = i_reg == rh_reg;
    assign status.emit       = emit_reg;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

    assign out_valid    = out_valid_reg;
    assign max_value    = out_max_reg;
    assign out_position = out_opos_reg;
    assign arg_position = out_arg_reg;
    assign last         = out_last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output register overwritten while held");

    a_fin_clears_pend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> !pend_valid_reg)
        else $error("pending result not flushed at end of sample");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> (i_reg <= rh_reg) && (j_reg <= ch_reg))
        else $error("window slot outside covered range");

endmodule

// File: rtl/mpa_ctrl.sv
// ----------------------------------------------------------------------------
// mpa_ctrl
// Sequencer: accept a sample, size the output plane after reset or a register write,
// find covered windows, then read-update each window slot and flush the pending result.
// ----------------------------------------------------------------------------
module mpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output mpa_pkg::cmd_t     cmd,
    input  mpa_pkg::status_t  status
);
    import mpa_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_DIM  = 9'b000000010,
        ST_DIMW = 9'b000000100,
        ST_DIV  = 9'b000001000,
        ST_DIVW = 9'b000010000,
        ST_RNG  = 9'b000100000,
        ST_RD   = 9'b001000000,
        ST_UPD  = 9'b010000000,
        ST_FIN  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.ok)
                    begin
                        state_next = status.dirty ? ST_DIM : ST_DIV;
                    end
                end
            end
            ST_DIM:
            begin
                cmd.dim_start = 1'b1;
                state_next    = ST_DIMW;
            end
            ST_DIMW:
            begin
                if (!status.div_busy)
                begin
                    cmd.dim_load = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_RNG;
                end
            end
            ST_RNG:
            begin
                cmd.rng_load = 1'b1;
                state_next   = status.rng_empty ? ST_FIN : ST_RD;
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (!(status.emit && status.pend_valid && !status.out_free))
                begin
                    cmd.upd = 1'b1;
                    if (!status.j_end)
                    begin
                        cmd.step_j = 1'b1;
                        state_next = ST_RD;
                    end
                    else if (!status.i_end)
                    begin
                        cmd.step_i = 1'b1;
                        state_next = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (!status.pend_valid || status.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = state_reg != ST_IDLE;

endmodule

// File: rtl/max_pool_2d_argmax.sv
// ----------------------------------------------------------------------------
// max_pool_2d_argmax
// Streaming 2-D max pooling with argmax over one raster-order plane.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   in       | in_valid / in_stall   | sample
//   out      | out_valid / out_stall | max_value, out_position, arg_position, last
//   cfg      | cfg_write             | cfg_index, cfg_data
//
// The time a sample takes grows with N, the number of windows covering it (up
// to 64); the two serial range dividers and the read and update of the
// partial store for each window set it.
// The first sample after reset or a register write first sizes the output
// plane. Reset needs no clearing pass over the store.
// out_stall holds the sequencer only when a new result meets a full output.
// ----------------------------------------------------------------------------
module max_pool_2d_argmax (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [mpa_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mpa_pkg::CFG_W-1:0]              cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [mpa_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [mpa_pkg::SAMPLE_BITS-1:0] max_value,
    output logic [mpa_pkg::OPOS_W-1:0]             out_position,
    output logic [mpa_pkg::ARG_W-1:0]              arg_position,
    output logic                                   last
);
    import mpa_pkg::*;

    cmd_t    cmd;
    status_t status;

    mpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    mpa_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .cmd          (cmd),
        .status       (status),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .max_value    (max_value),
        .out_position (out_position),
        .arg_position (arg_position),
        .last         (last)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming 2-D max pooling block with argmax.
// Planes are sent in raster order under several window settings. A
// predictor in the bench works out each window maximum, output index and
// argmax, and the results coming out are checked in order against them.
// Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import mpa_pkg::*;

    localparam int DRAIN_CYCLES = 300;
    localparam int IDLE_LIMIT   = 40000;
    localparam int EDGE_ITEMS   = 12;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] max_value;
        logic [OPOS_W-1:0]             out_position;
        logic [ARG_W-1:0]              arg_position;
        logic                          last;
    } pool_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_W-1:0]              cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] sample = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic [OPOS_W-1:0]             out_position;
    logic [ARG_W-1:0]              arg_position;
    logic                          last;

    pool_result_t pending_results[$];
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           stall_hold = 0;
    bit           no_idle = 1'b0;
    int           random_items = 0;

    // predictor state
    int unsigned kw, kh, sh, sv, ph, pv, iw, ih;
    int unsigned col_pos, row_pos;
    logic signed [SAMPLE_BITS-1:0] win_max [STORE_DEPTH];
    logic [ARG_W-1:0]              win_arg [STORE_DEPTH];

    max_pool_2d_argmax u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .max_value(max_value), .out_position(out_position),
        .arg_position(arg_position), .last(last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit settings_valid();
        if (kw < 1 || kw > MAX_KERNEL || kh < 1 || kh > MAX_KERNEL) return 0;
        if (sh < 1 || sv < 1) return 0;
        if (ph > kw / 2 || pv > kh / 2) return 0;
        if (iw < 1 || iw > MAX_WIDTH || ih < 1 || ih > MAX_HEIGHT) return 0;
        if (iw + 2 * ph < kw || ih + 2 * pv < kh) return 0;
        return 1;
    endfunction

    function automatic bit window_span(input int unsigned p, pad, k, s, n,
                                       output int unsigned lo, hi);
        int unsigned t;
        t  = p + pad;
        hi = t / s;
        lo = (t + 1 >= k) ? (t + 1 - k + s - 1) / s : 0;
        if (hi > n - 1) hi = n - 1;
        return lo <= hi;
    endfunction

    function automatic int unsigned first_real(input int unsigned w, s, pad);
        return (w * s > pad) ? w * s - pad : 0;
    endfunction

    function automatic int unsigned last_real(input int unsigned w, s, pad, k, size);
        int unsigned e;
        e = w * s + k - 1;
        e = (e > pad) ? e - pad : 0;
        return (e < size - 1) ? e : size - 1;
    endfunction

    task automatic pool_predict(input logic signed [SAMPLE_BITS-1:0] v);
        int unsigned  ow, oh, r, c, rl, rh, cl, ch, slot, arg;
        bit           top, bottom, opening, hit_r, hit_c;
        int           n, first_new;
        pool_result_t res;
        if (!settings_valid()) return;
        if (col_pos >= iw) col_pos = 0;
        if (row_pos >= ih) row_pos = 0;
        ow = (iw + 2 * ph - kw) / sh + 1;
        oh = (ih + 2 * pv - kh) / sv + 1;
        r = row_pos;
        c = col_pos;
        arg = c + iw * r;
        n = 0;
        first_new = pending_results.size();
        hit_r = window_span(r, pv, kh, sv, oh, rl, rh);
        hit_c = window_span(c, ph, kw, sh, ow, cl, ch);
        if (hit_r && hit_c)
        begin
            for (int unsigned i = rl; i <= rh; i++)
            begin
                top    = first_real(i, sv, pv) == r;
                bottom = last_real(i, sv, pv, kh, ih) == r;
                for (int unsigned j = cl; j <= ch; j++)
                begin
                    slot    = (i % MAX_KERNEL) * ROW_SLOTS + j;
                    opening = top && first_real(j, sh, ph) == c;
                    if (opening || v > win_max[slot])
                    begin
                        win_max[slot] = v;
                        win_arg[slot] = ARG_W'(arg);
                    end
                    if (bottom && n < 25 && last_real(j, sh, ph, kw, iw) == c)
                    begin
                        res.max_value    = win_max[slot];
                        res.out_position = OPOS_W'(j + ow * i);
                        res.arg_position = win_arg[slot];
                        res.last         = 1'b0;
                        pending_results.push_back(res);
                        n++;
                    end
                end
            end
        end
        if (n > 0) pending_results[first_new + n - 1].last = 1'b1;
        if (c + 1 >= iw)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= ih) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        do @(posedge clk); while (in_stall);
        pool_predict(v);
    endtask

    task automatic end_stream();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return SAMPLE_BITS'($signed($urandom_range(0, 4)) - 2);
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic wait_idle();
        end_stream();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(posedge clk);
        case (idx)
            CFG_KERNEL_W: kw = val & 4'hF;
            CFG_KERNEL_H: kh = val & 4'hF;
            CFG_STRIDE_H: sh = val & 4'hF;
            CFG_STRIDE_V: sv = val & 4'hF;
            CFG_PAD_H:    ph = val & 3'h7;
            CFG_PAD_V:    pv = val & 3'h7;
            CFG_IMAGE_W:  iw = val & 11'h7FF;
            CFG_IMAGE_H:  ih = val & 11'h7FF;
            default: ;
        endcase
    endtask

    task automatic set_pooling(input int unsigned k_w, k_h, s_h, s_v, p_h, p_v, i_w, i_h);
        wait_idle();
        write_reg(CFG_KERNEL_W, k_w);
        write_reg(CFG_KERNEL_H, k_h);
        write_reg(CFG_STRIDE_H, s_h);
        write_reg(CFG_STRIDE_V, s_v);
        write_reg(CFG_PAD_H, p_h);
        write_reg(CFG_PAD_V, p_v);
        write_reg(CFG_IMAGE_W, i_w);
        write_reg(CFG_IMAGE_H, i_h);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_plane();
        repeat (iw * ih) send_sample(rand_sample());
    endtask

    task automatic test_sample_extremes();
        set_pooling(1, 1, 1, 1, 0, 0, 3, 2);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh0000);
        send_sample(16'shFFFF);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
    endtask

    task automatic test_ties();
        set_pooling(2, 2, 1, 1, 0, 0, 3, 3);
        repeat (9) send_sample(16'sh0100);
    endtask

    task automatic test_padding();
        set_pooling(3, 3, 1, 1, 1, 1, 3, 3);
        send_plane();
    endtask

    task automatic test_wide_row();
        set_pooling(8, 8, 8, 8, 4, 4, MAX_WIDTH, 1);
        repeat (EDGE_ITEMS) send_sample(rand_sample());
    endtask

    task automatic test_tall_column();
        set_pooling(8, 8, 8, 8, 4, 4, 1, MAX_HEIGHT);
        repeat (EDGE_ITEMS) send_sample(rand_sample());
    endtask

    task automatic test_invalid_settings();
        set_pooling(0, 2, 2, 2, 0, 0, 4, 4);
        repeat (2) send_sample(rand_sample());
        set_pooling(9, 2, 2, 2, 0, 0, 4, 4);
        repeat (2) send_sample(rand_sample());
        set_pooling(2, 2, 0, 1, 0, 0, 4, 4);
        repeat (2) send_sample(rand_sample());
        set_pooling(2, 2, 1, 1, 2, 0, 4, 4);
        repeat (2) send_sample(rand_sample());
        set_pooling(2, 2, 1, 1, 0, 0, 0, 4);
        repeat (2) send_sample(rand_sample());
        set_pooling(2, 2, 1, 1, 0, 0, 4, 2047);
        repeat (2) send_sample(rand_sample());
        set_pooling(8, 2, 1, 1, 1, 0, 4, 4);
        repeat (2) send_sample(rand_sample());
        set_pooling(2, 2, 2, 2, 0, 0, 2, 2);
        send_plane();
    endtask

    task automatic test_counter_clamp();
        set_pooling(2, 2, 2, 2, 0, 0, 6, 6);
        repeat (27) send_sample(rand_sample());
        set_pooling(2, 3, 1, 2, 1, 1, 3, 3);
        send_plane();
    endtask

    task automatic test_random();
        int unsigned k_w, k_h, p_h, p_v, w_lo, h_lo, w_hi, h_hi;
        while (random_items < 30)
        begin
            k_w  = $urandom_range(1, 8);
            k_h  = $urandom_range(1, 8);
            p_h  = $urandom_range(0, k_w / 2);
            p_v  = $urandom_range(0, k_h / 2);
            w_lo = (k_w > 2 * p_h) ? k_w - 2 * p_h : 1;
            h_lo = (k_h > 2 * p_v) ? k_h - 2 * p_v : 1;
            w_hi = (w_lo > 6) ? w_lo : 6;
            h_hi = (h_lo > 6) ? h_lo : 6;
            set_pooling(k_w, k_h, $urandom_range(1, 8), $urandom_range(1, 8), p_h, p_v,
                        $urandom_range(w_lo, w_hi), $urandom_range(h_lo, h_hi));
            no_idle = ($urandom_range(0, 3) == 0);
            send_plane();
            random_items += iw * ih;
            no_idle = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || stall_hold == 0)
        begin
            out_stall  <= rst_n ? ($urandom_range(0, 2) == 0) : 1'b0;
            stall_hold <= gap_len();
        end
        else
        begin
            stall_hold <= stall_hold - 1;
        end
    end

    always @(posedge clk)
    begin
        pool_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: max %0d out %0d arg %0d last %0d",
                             max_value, out_position, arg_position, last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.max_value !== max_value || want.out_position !== out_position ||
                    want.arg_position !== arg_position || want.last !== last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp max %0d out %0d arg %0d last %0d,",
                                  " got max %0d out %0d arg %0d last %0d"},
                                 want.max_value, want.out_position, want.arg_position,
                                 want.last, max_value, out_position, arg_position, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        kw = 2; kh = 2; sh = 2; sv = 2; ph = 0; pv = 0;
        iw = MAX_WIDTH; ih = MAX_HEIGHT;
        col_pos = 0; row_pos = 0;
        for (int a = 0; a < STORE_DEPTH; a++)
        begin
            win_max[a] = '0;
            win_arg[a] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_sample_extremes();
        test_ties();
        test_padding();
        test_invalid_settings();
        test_counter_clamp();
        test_wide_row();
        test_tall_column();
        test_random();
        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mpa_pkg.sv
rtl/mpa_div.sv
rtl/mpa_datapath.sv
rtl/mpa_ctrl.sv
rtl/max_pool_2d_argmax.sv
tb/tb_top.sv
